// ----- hdl/gls_pkg.sv -----
// Shared types and constants of the grid line-of-sight block.
`default_nettype none
package gls_pkg;

	localparam int COORD_W = 6;
	localparam int ERR_W   = 10;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic signed [ERR_W-1:0] err_t;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	// Current tile of the line walk and where it lies on the line.
	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   at_start;
		logic   at_end;
	} walk_pos_t;

endpackage
`default_nettype wire

// ----- hdl/gls_ram.sv -----
// Generic single-port-write, registered-read RAM.
`default_nettype none
module gls_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- hdl/gls_walker.sv -----
// Bresenham line stepper: one tile of the line per advance.
`default_nettype none
module gls_walker
	import gls_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   load,
	input  wire logic   advance,
	input  wire coord_t start_x,
	input  wire coord_t start_y,
	input  wire coord_t end_x,
	input  wire coord_t end_y,
	output walk_pos_t   pos
);

	coord_t cx_q, cy_q, x0_q, y0_q, x1_q, y1_q;
	err_t   dx_q, dy_q, err_q;
	logic   sx_neg_q, sy_neg_q;
	logic   walking_q;

	err_t        dx_load, dy_load;
	logic signed [ERR_W:0] e2;
	logic        step_x, step_y;
	err_t        err_next;

	always_comb begin
		dx_load = (end_x >= start_x) ? err_t'(end_x - start_x) : err_t'(start_x - end_x);
		dy_load = (end_y >= start_y) ? -err_t'(end_y - start_y) : -err_t'(start_y - end_y);
		e2      = {err_q, 1'b0};
		step_x  = e2 >= (ERR_W+1)'(dy_q);
		step_y  = e2 <= (ERR_W+1)'(dx_q);
		err_next = err_q + (step_x ? dy_q : err_t'(0)) + (step_y ? dx_q : err_t'(0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walking_q <= 1'b0;
		end else if (load) begin
			walking_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cx_q     <= start_x;
			cy_q     <= start_y;
			x0_q     <= start_x;
			y0_q     <= start_y;
			x1_q     <= end_x;
			y1_q     <= end_y;
			dx_q     <= dx_load;
			dy_q     <= dy_load;
			err_q    <= dx_load + dy_load;
			sx_neg_q <= !(start_x < end_x);
			sy_neg_q <= !(start_y < end_y);
		end else if (advance && walking_q) begin
			err_q <= err_next;
			if (step_x) begin
				cx_q <= sx_neg_q ? cx_q - coord_t'(1) : cx_q + coord_t'(1);
			end
			if (step_y) begin
				cy_q <= sy_neg_q ? cy_q - coord_t'(1) : cy_q + coord_t'(1);
			end
		end
	end

	assign pos.x        = cx_q;
	assign pos.y        = cy_q;
	assign pos.at_start = (cx_q == x0_q) && (cy_q == y0_q);
	assign pos.at_end   = (cx_q == x1_q) && (cy_q == y1_q);

endmodule
`default_nettype wire

// ----- hdl/grid_line_of_sight.sv -----
// Top level of the grid line-of-sight block: wall map, walk sequencer and result register.
//
// Channel  Direction  Transfer carries
// s_*      in         one write item (store a wall bit) or one query item (test a line)
// m_*      out        one result per query: sight_clear; writes give no result
//
// A write is stored as it is taken in. A query is taken in and then walked
// tile by tile over the line, with one map read for each tile strictly between
// the endpoints that lies on the map; the single read port of the wall map
// sets the pace of the walk. Input is taken only while no query is being
// walked. A finished result waits in the output register; if that register
// is still full when the next query ends, the walk holds on its last tile.
// Reset clears control state only; the wall map is undefined until written,
// so no clearing pass follows reset.
`default_nettype none
module grid_line_of_sight
	import gls_pkg::*;
#(
	parameter int MAP_COLUMNS = 64,
	parameter int MAP_ROWS    = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // start_x, start_y, end_x, end_y, wall_bit, zero pad
	input  wire logic [0:0]  s_tuser,   // cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata    // sight_clear, zero pad
);

	localparam int ADDR_W = $clog2(MAP_COLUMNS * MAP_ROWS);
	localparam logic [8:0] COLS_LIM = 9'(MAP_COLUMNS);
	localparam logic [8:0] ROWS_LIM = 9'(MAP_ROWS);

	// Unpacked input fields.
	cmd_t   in_cmd;
	coord_t in_start_x, in_start_y, in_end_x, in_end_y;
	logic   in_wall_bit;

	assign in_cmd      = cmd_t'(s_tuser[0]);
	assign in_start_x  = s_tdata[5:0];
	assign in_start_y  = s_tdata[11:6];
	assign in_end_x    = s_tdata[17:12];
	assign in_end_y    = s_tdata[23:18];
	assign in_wall_bit = s_tdata[24];

	state_t state_q, state_next;
	logic   in_xfer, query_load, out_free, finish;
	logic   mem_we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic   rd_wall;
	logic   chk_s1, blocked_q;
	logic   tile_in_map, tile_check;
	logic   m_tvalid_q, sight_clear_q;
	walk_pos_t pos;

	assign s_tready   = (state_q == ST_IDLE);
	assign in_xfer    = s_tvalid && s_tready;
	assign query_load = in_xfer && (in_cmd == CMD_QUERY);
	assign out_free   = !m_tvalid_q || m_tready;

	// Writes outside the map are dropped.
	assign mem_we = in_xfer && (in_cmd == CMD_WRITE)
		&& ({3'b000, in_start_x} < COLS_LIM) && ({3'b000, in_start_y} < ROWS_LIM);
	assign waddr = ADDR_W'(32'(in_start_y) * MAP_COLUMNS + 32'(in_start_x));

	gls_walker u_walker (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (query_load),
		.advance ((state_q == ST_WALK) && !pos.at_end),
		.start_x (in_start_x),
		.start_y (in_start_y),
		.end_x   (in_end_x),
		.end_y   (in_end_y),
		.pos     (pos)
	);

	// Tiles off the map count as open; their read address is never used.
	assign tile_in_map = ({3'b000, pos.x} < COLS_LIM) && ({3'b000, pos.y} < ROWS_LIM);
	assign raddr       = ADDR_W'(32'(pos.y) * MAP_COLUMNS + 32'(pos.x));
	assign tile_check  = (state_q == ST_WALK) && !pos.at_start && !pos.at_end && tile_in_map;

	gls_ram #(
		.WIDTH (1),
		.DEPTH (MAP_COLUMNS * MAP_ROWS)
	) u_wall_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wdata (in_wall_bit),
		.raddr (raddr),
		.rdata (rd_wall)
	);

	// The walk ends on the far endpoint; the read of the tile before it
	// returns as the walk reaches it and goes into the result directly, or via blocked_q if the walk holds.
	assign finish = (state_q == ST_WALK) && pos.at_end && out_free;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (query_load) begin
					state_next = ST_WALK;
				end
			end
			ST_WALK: begin
				if (finish) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			chk_s1     <= 1'b0;
			blocked_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			chk_s1  <= tile_check;
			if (query_load) begin
				blocked_q <= 1'b0;
			end else if (chk_s1 && rd_wall) begin
				blocked_q <= 1'b1;
			end
			if (finish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			sight_clear_q <= !(blocked_q || (chk_s1 && rd_wall));
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0000000, sight_clear_q};

	// A query transfer always starts a walk.
	a_query_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		query_load |=> (state_q == ST_WALK))
		else $error("query transfer did not start a walk");

	// A map check in flight can only come from a walk step.
	a_check_from_walk: assert property (@(posedge clk) disable iff (!arst_n)
		chk_s1 |-> $past(state_q == ST_WALK))
		else $error("map check issued outside a walk");

	// A new result appears only as a walk ends.
	a_result_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_WALK))
		else $error("result appeared without a walk");

	// The map is never written while a walk reads it.
	a_no_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_IDLE))
		else $error("wall map written during a walk");

endmodule
`default_nettype wire
